// ===== sv/bqn_pkg.sv =====
package bqn_pkg;

    localparam int MAX_STAGES_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 32;

    localparam int NCOEF     = 5;
    localparam int ACC_BITS  = 48;
    localparam int FRAC_BITS = 31;
    localparam int CFG_ADDR_BITS = 4;

    // request modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // coefficient selects
    localparam logic [2:0] CSEL_B0 = 3'd0;
    localparam logic [2:0] CSEL_B1 = 3'd1;
    localparam logic [2:0] CSEL_B2 = 3'd2;
    localparam logic [2:0] CSEL_A1 = 3'd3;
    localparam logic [2:0] CSEL_A2 = 3'd4;

    // register byte addresses
    localparam logic [CFG_ADDR_BITS-1:0] REG_FILTER_EN = 4'h0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NORM_EN   = 4'h4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STAGES    = 4'h8;

    // divider request/response
    typedef struct packed {
        logic                start;
        logic                neg;
        logic [ACC_BITS+15:0] dividend;
        logic [ACC_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [ACC_BITS+15:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/bqn_mac.sv =====
// Shared multiply unit: floor(c * v / 2^24), computed in a low phase and a high phase by
// splitting v into a high part and a 24-bit low part (each product <= 32x32).
module bqn_mac #(
    parameter int COEF_BITS = bqn_pkg::COEF_BITS_DEF
) (
    input  logic                           clk,
    input  logic signed [COEF_BITS-1:0]    c,
    input  logic signed [bqn_pkg::ACC_BITS-1:0] v,
    input  logic                           phase,
    output logic signed [bqn_pkg::ACC_BITS-24+COEF_BITS+1:0] prod
);
    import bqn_pkg::*;

    localparam int HI_BITS = ACC_BITS - 24;

    logic signed [HI_BITS+COEF_BITS-1:0] hi_reg;
    logic signed [24+COEF_BITS:0]        lo_reg;
    logic signed [HI_BITS-1:0]           v_hi;
    logic signed [24:0]                  v_lo;

    assign v_hi = v[ACC_BITS-1:24];
    assign v_lo = $signed({1'b0, v[23:0]});

    // phase 0 takes the low product, phase 1 the high product
    always_ff @(posedge clk)
    begin
        if (!phase)
        begin
            lo_reg <= v_lo * c;
        end
        else
        begin
            hi_reg <= v_hi * c;
        end
    end

    // full-width product, no truncation
    logic signed [HI_BITS+COEF_BITS+1:0] sum;
    always_comb
    begin
        sum  = (HI_BITS+COEF_BITS+2)'(hi_reg)
             + (HI_BITS+COEF_BITS+2)'(lo_reg >>> 24);
        prod = sum;
    end
endmodule

// ===== sv/bqn_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module bqn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bqn_pkg::div_req_t req,
    output bqn_pkg::div_rsp_t rsp
);
    import bqn_pkg::*;

    localparam int QB = ACC_BITS + 16;
    localparam int CB = $clog2(QB + 1);

    logic [QB-1:0]       q_reg;
    logic [ACC_BITS:0]   r_reg;
    logic [ACC_BITS-1:0] d_reg;
    logic [CB-1:0]       cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic                done_reg;
    logic [ACC_BITS:0]   r_sh;
    logic [ACC_BITS:0]   r_sub;

    always_comb
    begin
        r_sh  = {r_reg[ACC_BITS-1:0], q_reg[QB-1]};
        r_sub = r_sh - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(QB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            r_reg   <= '0;
            d_reg   <= req.divisor;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            if (!r_sub[ACC_BITS])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[QB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = neg_reg ? -q_reg : q_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != '0)
        else $error("divider count underflow");
endmodule

// ===== sv/biquad_cascade_normalized_top.sv =====
// Cascaded transposed direct form II biquad filter with running-peak
// normalization. One request is taken at a time; in_ready is low while it is
// worked on. A sample request runs five products per active stage on one
// shared multiplier, each product stepping through S_RD, S_M0, S_M1 and
// S_NEXT. With normalization on, a 64-step serial divider follows; S_OUT
// then loads the result into the output register. With the filter disabled
// the sample comes back the cycle after acceptance. Coefficient writes,
// clears and the unused mode finish at the accepting edge. A finished
// result waits in the output register; while it is held and out_ready is
// low, in_ready is low. Coefficients sit in a small memory with a
// registered read and are undefined until written. Registers: filter enable
// at 0x0, normalize enable at 0x4, stage count at 0x8.
module biquad_cascade_normalized_top #(
    parameter int MAX_STAGES  = bqn_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = bqn_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqn_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [2:0]                    stage,
    input  logic [2:0]                    coef_select,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          saturated,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bqn_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bqn_pkg::*;

    localparam int SB    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DEPTH = MAX_STAGES * NCOEF;
    localparam int AB    = $clog2(DEPTH);
    localparam int NB    = $clog2(MAX_STAGES + 1);
    localparam int PW    = ACC_BITS - 24 + COEF_BITS + 2;
    localparam int AW    = PW + 2;
    localparam logic signed [ACC_BITS-1:0] MAXV = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] MINV = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ONE  = ACC_BITS'(1) <<< FRAC_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_M0    = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_NEXT  = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    // configuration registers
    logic       fen_reg, nen_reg;
    logic [3:0] nst_reg;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fen_reg <= 1'b1;
            nen_reg <= 1'b1;
            nst_reg <= 4'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_FILTER_EN: fen_reg <= pwdata[0];
                REG_NORM_EN:   nen_reg <= pwdata[0];
                REG_STAGES:    nst_reg <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_FILTER_EN: prdata = {31'd0, fen_reg};
            REG_NORM_EN:   prdata = {31'd0, nen_reg};
            REG_STAGES:    prdata = {28'd0, nst_reg};
            default:       prdata = '0;
        endcase
    end

    // coefficient memory
    logic [COEF_BITS-1:0] cmem [DEPTH];
    logic [COEF_BITS-1:0] crd_reg;
    logic [AB-1:0]        craddr;
    logic                 cwe;
    logic [AB-1:0]        cwaddr;

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            cmem[cwaddr] <= coef_value;
        end
        crd_reg <= cmem[craddr];
    end

    // state
    logic [3:0]                  st_reg;
    logic signed [ACC_BITS-1:0]  d1 [MAX_STAGES];
    logic signed [ACC_BITS-1:0]  d2 [MAX_STAGES];
    logic signed [ACC_BITS-1:0]  peak_reg;
    logic signed [ACC_BITS-1:0]  x_reg, y_reg;
    logic signed [AW-1:0]        acc_reg;
    logic [SB-1:0]               si_reg;
    logic [NB-1:0]               nlim_reg;
    logic [2:0]                  k_reg;
    logic                        ph_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic                        sat_reg;
    logic                        ov_reg;

    // output register free, or being emptied this cycle
    logic out_free;
    assign out_free = !ov_reg || out_ready;

    assign in_ready  = (st_reg == S_IDLE) && out_free;
    assign out_valid = ov_reg;
    assign filtered  = res_reg;
    assign saturated = sat_reg;

    logic acc_in;
    assign acc_in = in_valid && in_ready;

    logic res_load;
    assign res_load = (acc_in && mode == MODE_SAMPLE && !fen_reg)
                   || (st_reg == S_OUT && out_free);

    // section index wrapped into the range 0 to MAX_STAGES-1
    function automatic logic [2:0] stage_wrap(input logic [2:0] s);
        logic [2:0] r;
        r = s;
        for (int i = 0; i < 8; i++)
            if (32'(r) >= MAX_STAGES)
                r = r - 3'(MAX_STAGES);
        return r;
    endfunction

    // coefficient order per stage: b0, a1, b1, b2, a2
    logic [2:0] ksel;
    always_comb
    begin
        case (k_reg)
            3'd0:    ksel = CSEL_B0;
            3'd1:    ksel = CSEL_A1;
            3'd2:    ksel = CSEL_B1;
            3'd3:    ksel = CSEL_B2;
            default: ksel = CSEL_A2;
        endcase
    end
    assign craddr = AB'(si_reg * NCOEF + ksel);
    assign cwaddr = AB'(stage_wrap(stage) * NCOEF + coef_select);
    assign cwe    = acc_in && (mode == MODE_COEF) && (coef_select <= CSEL_A2);

    // shared multiplier
    logic signed [PW-1:0]       prod;
    logic signed [ACC_BITS-1:0] mv;
    assign mv = (k_reg == 3'd1 || k_reg == 3'd4) ? y_reg : x_reg;

    bqn_mac #(.COEF_BITS(COEF_BITS)) u_mac (
        .clk   (clk),
        .c     ($signed(crd_reg)),
        .v     (mv),
        .phase (ph_reg),
        .prod  (prod)
    );

    function automatic logic signed [ACC_BITS-1:0] sat48(
        input logic signed [AW-1:0] v
    );
        if (v > AW'(MAXV))
            sat48 = MAXV;
        else if (v < AW'(MINV))
            sat48 = MINV;
        else
            sat48 = ACC_BITS'(v);
    endfunction

    logic signed [AW-1:0] addv;
    assign addv = acc_reg + AW'(prod);

    // divider
    div_req_t dreq;
    div_rsp_t drsp;
    bqn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // true magnitude for the quotient, clipped magnitude for the peak
    logic [ACC_BITS-1:0] ymag;
    logic [ACC_BITS-1:0] ymag_sat;
    assign ymag     = y_reg[ACC_BITS-1] ? ACC_BITS'(-y_reg) : y_reg;
    assign ymag_sat = ymag[ACC_BITS-1] ? MAXV : ymag;

    always_comb
    begin
        dreq.start    = (st_reg == S_NORM) && nen_reg;
        dreq.neg      = y_reg[ACC_BITS-1];
        dreq.dividend = (ACC_BITS+16)'(ymag) << (SAMPLE_BITS - 1);
        dreq.divisor  = ($signed(ymag_sat) > peak_reg) ? ymag_sat : peak_reg;
    end

    logic signed [ACC_BITS+15:0] rfin;
    logic signed [ACC_BITS+15:0] smaxw, sminw;
    always_comb
    begin
        smaxw = (ACC_BITS+16)'((1 <<< (SAMPLE_BITS-1)) - 1);
        sminw = -smaxw - 1;
        if (nen_reg)
            rfin = $signed(drsp.quot);
        else
            rfin = (ACC_BITS+16)'(y_reg >>> (32 - SAMPLE_BITS));
    end

    // result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (res_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            peak_reg <= ONE;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                d1[i] <= '0;
                d2[i] <= '0;
            end
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (acc_in && mode == MODE_CLEAR)
                    begin
                        peak_reg <= ONE;
                        for (int i = 0; i < MAX_STAGES; i++)
                        begin
                            d1[i] <= '0;
                            d2[i] <= '0;
                        end
                    end
                    else if (acc_in && mode == MODE_SAMPLE)
                    begin
                        if (!fen_reg)
                        begin
                            res_reg <= sample;
                            sat_reg <= 1'b0;
                        end
                        else
                        begin
                            x_reg <= ACC_BITS'(sample) <<< (32 - SAMPLE_BITS);
                            si_reg <= '0;
                            k_reg  <= '0;
                            nlim_reg <= (nst_reg == 0) ? NB'(1) :
                                        (32'(nst_reg) > MAX_STAGES) ? NB'(MAX_STAGES) :
                                        NB'(nst_reg);
                            st_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    ph_reg <= 1'b0;
                    case (k_reg)
                        3'd0:    acc_reg <= AW'(d1[si_reg]);
                        3'd1:    acc_reg <= AW'(d2[si_reg]);
                        3'd3:    acc_reg <= '0;
                        default: ;
                    endcase
                    st_reg <= S_M0;
                end
                S_M0:
                begin
                    ph_reg <= 1'b1;
                    st_reg <= S_M1;
                end
                S_M1:
                begin
                    st_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    case (k_reg)
                        3'd0:
                        begin
                            y_reg <= sat48(addv);
                            k_reg <= 3'd1;
                            st_reg <= S_RD;
                        end
                        3'd1:
                        begin
                            acc_reg <= addv;
                            k_reg <= 3'd2;
                            st_reg <= S_RD;
                        end
                        3'd2:
                        begin
                            d1[si_reg] <= sat48(addv);
                            k_reg <= 3'd3;
                            st_reg <= S_RD;
                        end
                        3'd3:
                        begin
                            acc_reg <= addv;
                            k_reg <= 3'd4;
                            st_reg <= S_RD;
                        end
                        default:
                        begin
                            d2[si_reg] <= sat48(addv);
                            x_reg <= y_reg;
                            k_reg <= '0;
                            if (NB'(si_reg) + 1'b1 == nlim_reg)
                                st_reg <= S_NORM;
                            else
                            begin
                                si_reg <= si_reg + 1'b1;
                                st_reg <= S_RD;
                            end
                        end
                    endcase
                end
                S_NORM:
                begin
                    if (nen_reg)
                    begin
                        if ($signed(ymag_sat) > peak_reg)
                            peak_reg <= ymag_sat;
                        st_reg <= S_DIV;
                    end
                    else
                        st_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (drsp.done)
                        st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register can take the result
                    if (out_free)
                    begin
                        if (rfin > smaxw)
                        begin
                            res_reg <= SAMPLE_BITS'(smaxw);
                            sat_reg <= 1'b1;
                        end
                        else if (rfin < sminw)
                        begin
                            res_reg <= SAMPLE_BITS'(sminw);
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            res_reg <= SAMPLE_BITS'(rfin);
                            sat_reg <= 1'b0;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // the peak never drops below its clear value
    assert property (@(posedge clk) disable iff (!rst_n) peak_reg >= ONE)
        else $error("peak below one");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_OUT) |=> out_valid)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DIV) |-> nen_reg)
        else $error("divide without normalization");
endmodule

// ===== sim/biquad_cascade_normalized_top_tb.sv =====
module biquad_cascade_normalized_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bqn_pkg::*;

    localparam int NSTG = 8;
    localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
    localparam longint ACC_MIN = -(64'sd1 <<< 47);
    localparam longint UNITY   = 64'sd1 <<< 31;

    // expected filter output
    typedef struct {
        logic signed [15:0] filtered;
        logic               saturated;
    } filt_out_t;

    // scoreboard: carries its own copy of the filter state
    class filter_scoreboard;
        logic signed [31:0] coefs [NSTG*NCOEF];
        longint d1 [NSTG];
        longint d2 [NSTG];
        longint peak;
        bit fen, nen;
        logic [3:0] nstg;
        filt_out_t pending [$];
        int errors;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            clear_delays();
            fen = 1; nen = 1; nstg = 1;
            errors = 0;
        endfunction

        function void clear_delays();
            foreach (d1[i])
            begin
                d1[i] = 0;
                d2[i] = 0;
            end
            peak = UNITY;
        endfunction

        function longint floor_shift(longint v, int k);
            return v >>> k;
        endfunction

        function longint clamp48(longint v);
            if (v > ACC_MAX) return ACC_MAX;
            if (v < ACC_MIN) return ACC_MIN;
            return v;
        endfunction

        // floor(c*v/2^24), exact
        function longint coef_mul(longint c, longint v);
            longint hi, lo;
            hi = v >>> 24;
            lo = v - (hi <<< 24);
            return hi * c + ((lo * c) >>> 24);
        endfunction

        function void note_request(logic [1:0] md, logic signed [15:0] smp, logic [2:0] stg,
                                   logic [2:0] csel, logic signed [31:0] cval);
            filt_out_t r;
            longint x, y, mag, q;
            int n;
            if (md == MODE_COEF)
            begin
                if (csel <= CSEL_A2) coefs[stg*NCOEF + csel] = cval;
                return;
            end
            if (md == MODE_CLEAR)
            begin
                clear_delays();
                return;
            end
            if (md != MODE_SAMPLE) return;
            r.saturated = 0;
            if (!fen)
            begin
                r.filtered = smp;
                pending.push_back(r);
                return;
            end
            n = (nstg < 1) ? 1 : ((nstg > NSTG) ? NSTG : nstg);
            x = longint'(smp) <<< 16;
            y = x;
            for (int i = 0; i < n; i++)
            begin
                y = clamp48(d1[i] + coef_mul(coefs[i*NCOEF+CSEL_B0], x));
                d1[i] = clamp48(d2[i] + coef_mul(coefs[i*NCOEF+CSEL_A1], y)
                                + coef_mul(coefs[i*NCOEF+CSEL_B1], x));
                d2[i] = clamp48(coef_mul(coefs[i*NCOEF+CSEL_B2], x)
                                + coef_mul(coefs[i*NCOEF+CSEL_A2], y));
                x = y;
            end
            if (nen)
            begin
                mag = (y < 0) ? -y : y;
                if (mag > ACC_MAX) mag = ACC_MAX;
                if (mag > peak) peak = mag;
                q = (y <<< 15) / peak;
            end
            else
                q = y >>> 16;
            if (q > 32767)
            begin
                q = 32767;
                r.saturated = 1;
            end
            else if (q < -32768)
            begin
                q = -32768;
                r.saturated = 1;
            end
            r.filtered = q[15:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [15:0] f, logic s);
            filt_out_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result filtered=%0d saturated=%0b", $time, f, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (f !== e.filtered)
            begin
                $display("%0t: filtered expected %0d actual %0d", $time, e.filtered, f);
                errors++;
            end
            if (s !== e.saturated)
            begin
                $display("%0t: saturated expected %0b actual %0b", $time, e.saturated, s);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_ready;
    logic [1:0] mode = '0;
    logic signed [15:0] sample = '0;
    logic [2:0] stage = '0, coef_select = '0;
    logic signed [31:0] coef_value = '0;
    logic out_valid, out_ready = 0;
    logic signed [15:0] filtered;
    logic saturated;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    filter_scoreboard sb = new();
    bit driving_done = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    biquad_cascade_normalized_top uut (.*);

    // APB register write
    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        if (addr == REG_FILTER_EN) sb.fen = data[0];
        else if (addr == REG_NORM_EN) sb.nen = data[0];
        else if (addr == REG_STAGES) sb.nstg = data[3:0];
    endtask

    task automatic send_request(logic [1:0] md, logic signed [15:0] smp, logic [2:0] stg,
                                logic [2:0] csel, logic signed [31:0] cval);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge clk);
        in_valid = 1; mode = md; sample = smp; stage = stg;
        coef_select = csel; coef_value = cval;
        do @(posedge clk); while (!in_ready);
        sb.note_request(md, smp, stg, csel, cval);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_sample(logic signed [15:0] smp);
        send_request(MODE_SAMPLE, smp, 3'($urandom), 3'($urandom), 32'($urandom));
    endtask

    task automatic write_coef(logic [2:0] stg, logic [2:0] csel, logic signed [31:0] v);
        send_request(MODE_COEF, 16'($urandom), stg, csel, v);
    endtask

    // Q8.24 value within +-2^(span_bits-24); smaller span_bits keep the gain modest
    function automatic logic signed [31:0] rand_coef(int span_bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (31 - span_bits);
    endfunction

    // fully define every coefficient
    task automatic load_coefs(int span_bits);
        for (int s = 0; s < NSTG; s++)
            for (int k = 0; k < NCOEF; k++)
                write_coef(3'(s), 3'(k), rand_coef(span_bits));
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    // result side with random stalls
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            out_ready = 0;
            repeat (stall) @(negedge clk);
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(filtered, saturated);
        end
    end

    // stimulus
    initial
    begin
        logic [3:0] stg_set;
        int span;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: fixed coefficients with unity b0, extremes, ignored selects, unused mode
        for (int s = 0; s < NSTG; s++)
        begin
            write_coef(3'(s), CSEL_B0, 32'sh0100_0000);
            write_coef(3'(s), CSEL_B1, 32'sh0080_0000);
            write_coef(3'(s), CSEL_B2, 32'sh0040_0000);
            write_coef(3'(s), CSEL_A1, 32'shFF80_0000);
            write_coef(3'(s), CSEL_A2, 32'sh0020_0000);
        end
        write_coef(3'd0, 3'd5, 32'sh7FFF_FFFF);
        write_coef(3'd1, 3'd7, 32'sh8000_0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_request(MODE_UNUSED, 16'sh1234, 3'd7, 3'd7, 32'sh1);
        send_request(MODE_CLEAR, 16'sh0, 3'd0, 3'd0, 32'sh0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_idle();
        write_reg(REG_NORM_EN, 32'h0);
        write_reg(REG_STAGES, 32'h8);
        write_coef(3'd7, CSEL_B0, 32'sh7FFF_FFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        wait_idle();
        write_reg(REG_FILTER_EN, 32'h0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_idle();
        write_reg(REG_FILTER_EN, 32'hFFFF_FFFF);
        write_reg(REG_STAGES, 32'h0);
        send_sample(16'sh4000);
        wait_idle();
        write_reg(REG_STAGES, 32'hF);
        send_sample(16'shC000);
        wait_idle();

        // random phases, each with its own settings
        for (int ph = 0; ph < 16; ph++)
        begin
            stg_set = (ph % 4 == 0) ? 4'd8 : (ph % 4 == 1 ? 4'd1 : 4'($urandom_range(0, 15)));
            write_reg(REG_FILTER_EN, (ph % 7 == 6) ? 32'h0 : 32'h1);
            write_reg(REG_NORM_EN, {31'b0, ph[0]});
            write_reg(REG_STAGES, {28'b0, stg_set});
            send_request(MODE_CLEAR, 16'($urandom), 3'($urandom), 3'($urandom), $urandom);
            span = (ph % 5 == 4) ? 31 : $urandom_range(20, 25);
            load_coefs(span);
            for (int i = 0; i < 60; i++)
            begin
                case ($urandom_range(0, 19))
                    0: write_coef(3'($urandom), 3'($urandom_range(0, 7)), rand_coef(span));
                    1: send_request(MODE_CLEAR, 16'($urandom), 3'($urandom), 3'($urandom),
                                    $urandom);
                    2: send_request(MODE_UNUSED, 16'($urandom), 3'($urandom), 3'($urandom),
                                    $urandom);
                    default: send_sample(16'($urandom));
                endcase
            end
            wait_idle();
        end
        driving_done = 1;
    end

    // final check
    initial
    begin
        wait (driving_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run time limit
    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bqn_pkg.sv
sv/bqn_mac.sv
sv/bqn_div.sv
sv/biquad_cascade_normalized_top.sv
sim/biquad_cascade_normalized_top_tb.sv
